// ===== rtl/tpsg_pkg.sv =====
// ============================================================================
// tpsg_pkg
// Shared types, control word layout, microcode and sine table generation
// for the three-phase sine generator.
// ============================================================================
package tpsg_pkg;

    // Configuration register indexes
    localparam logic REG_PHASE_GAIN = 1'b0;
    localparam logic REG_DC_LEVEL   = 1'b1;

    localparam logic [15:0] PHASE_GAIN_RESET = 16'd10737;
    localparam logic [9:0]  DC_LEVEL_RESET   = 10'd540;

    localparam int CFG_DATA_BITS = 16;
    localparam int SPEED_BITS    = 15;
    localparam int AMP_BITS      = 10;
    localparam int RIPPLE_BITS   = 8;
    localparam int RESULT_BITS   = 11;

    // Largest legal bus value: DC level plus full ripple.
    localparam logic [RESULT_BITS-1:0] DC_BUS_MAX = 11'd1278;

    // Quarter turn in Q30, used by the sine series.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Series divisors (2k)(2k+1) for k = 1..12.
    localparam logic [63:0] SERIES_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Step counter of the sequencer.
    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t STEP_FETCH = 4'd0;
    localparam step_t STEP_MUL   = 4'd1;
    localparam step_t LAST_STEP  = 4'd9;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_INC,
        MUL_AMP,
        MUL_RIP
    } mul_sel_t;

    typedef enum logic [1:0] {
        OFS_ZERO,
        OFS_THIRD,
        OFS_TWO_THIRDS,
        OFS_QUARTER
    } ofs_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_A,
        WR_B,
        WR_C,
        WR_BUS
    } wr_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_HOLD_IN,
        JMP_HOLD_OUT
    } jmp_t;

    typedef struct packed {
        logic     take_in;
        mul_sel_t mul_sel;
        logic     acc_upd;
        ofs_sel_t ofs_sel;
        wr_sel_t  wr_sel;
        logic     emit;
        jmp_t     jmp;
        step_t    target;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } stat_t;

    // Microprogram. The sine table read is registered, so a phase address
    // issued in one step feeds the multiplier in the next step, and the
    // product is scaled and stored in the step after that.
    function automatic ctl_t ucode(step_t step);
        ctl_t c;
        c = ctl_t'('0);
        unique case (step)
            4'd0:
            begin
                c.take_in = 1'b1;
                c.jmp     = JMP_HOLD_IN;
                c.target  = STEP_MUL;
            end
            4'd1: c.mul_sel = MUL_INC;
            4'd2: c.acc_upd = 1'b1;
            4'd3: c.ofs_sel = OFS_ZERO;
            4'd4:
            begin
                c.ofs_sel = OFS_THIRD;
                c.mul_sel = MUL_AMP;
            end
            4'd5:
            begin
                c.ofs_sel = OFS_TWO_THIRDS;
                c.mul_sel = MUL_AMP;
                c.wr_sel  = WR_A;
            end
            4'd6:
            begin
                c.ofs_sel = OFS_QUARTER;
                c.mul_sel = MUL_AMP;
                c.wr_sel  = WR_B;
            end
            4'd7:
            begin
                c.mul_sel = MUL_RIP;
                c.wr_sel  = WR_C;
            end
            4'd8: c.wr_sel = WR_BUS;
            4'd9:
            begin
                c.emit   = 1'b1;
                c.jmp    = JMP_HOLD_OUT;
                c.target = STEP_FETCH;
            end
            default: c = ctl_t'('0);
        endcase
        return c;
    endfunction

    // Quarter-wave sine entry, evaluated at elaboration time only.
    function automatic logic [31:0] sine_entry(int unsigned idx, int unsigned addr_bits,
                                               int unsigned out_bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] peak;
        x    = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (addr_bits + 1);
        term = x;
        sum  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[k];
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        peak = (64'd1 << (out_bits - 1)) - 64'd1;
        return 32'((sum * peak + (64'd1 << 29)) >> 30);
    endfunction

endpackage

// ===== rtl/three_phase_sine_generator_core.sv =====
// ============================================================================
// three_phase_sine_generator_core
// Three-phase sine synthesizer: phase accumulator, quarter-wave table and
// one shared multiplier under a microcoded sequencer.
// ============================================================================
//
//   Port group   Direction  Handshake               Contents
//   in_*         input      in_valid / in_stall     speed_rpm, amplitude, ripple
//   out_*        output     out_valid / out_stall   phase_a, phase_b, phase_c, dc_bus
//   cfg_*        input      cfg_wr_en               0: phase_gain, 1: dc_level
//
// A request runs through the ten-step microprogram from acceptance to the result register,
// and no new request is taken before the program is through: it runs one multiplier through
// the speed product and four sine products.
// The next request is accepted as soon as the program returns to its first step,
// even while the previous result is still held in the output register.
// A result that is still stalled holds the program in its last step.
// Reset clears the phase accumulator and loads the register defaults; no clearing pass.
//
module three_phase_sine_generator_core #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SINE_OUT_BITS  = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic                                    cfg_index,
    input  logic [tpsg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [tpsg_pkg::SPEED_BITS-1:0]         speed_rpm,
    input  logic [tpsg_pkg::AMP_BITS-1:0]           amplitude,
    input  logic [tpsg_pkg::RIPPLE_BITS-1:0]        ripple,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_a,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_b,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_c,
    output logic [tpsg_pkg::RESULT_BITS-1:0]        dc_bus
);

    tpsg_pkg::ctl_t            ctl;
    tpsg_pkg::stat_t           status;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [SINE_OUT_BITS-2:0]  rom_data;

    assign in_stall = !ctl.take_in;

    tpsg_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    tpsg_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS),
        .DATA_BITS (SINE_OUT_BITS - 1)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    tpsg_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SINE_OUT_BITS  (SINE_OUT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .speed_rpm (speed_rpm),
        .amplitude (amplitude),
        .ripple    (ripple),
        .rom_addr  (rom_addr),
        .rom_data  (rom_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .phase_a   (phase_a),
        .phase_b   (phase_b),
        .phase_c   (phase_c),
        .dc_bus    (dc_bus)
    );

endmodule

// ===== rtl/tpsg_sine_rom.sv =====
// ============================================================================
// tpsg_sine_rom
// Quarter-wave sine table with a registered read port.
// ============================================================================
module tpsg_sine_rom #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 11
) (
    input  logic                 clk,
    input  logic [ADDR_BITS-1:0] addr,
    output logic [DATA_BITS-1:0] data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] rom_tbl [DEPTH];
    logic [DATA_BITS-1:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        assign rom_tbl[g] = DATA_BITS'(tpsg_pkg::sine_entry(g, ADDR_BITS, DATA_BITS + 1));
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_tbl[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/tpsg_sequencer.sv =====
// ============================================================================
// tpsg_sequencer
// Step counter and microcode table; issues one control word per cycle.
// ============================================================================
module tpsg_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  tpsg_pkg::stat_t status,
    output tpsg_pkg::ctl_t  ctl
);

    tpsg_pkg::step_t step_reg;
    tpsg_pkg::step_t step_next;

    assign ctl = tpsg_pkg::ucode(step_reg);

    always_comb
    begin
        step_next = step_reg + tpsg_pkg::step_t'(1);
        unique case (ctl.jmp)
            tpsg_pkg::JMP_NEXT:     step_next = step_reg + tpsg_pkg::step_t'(1);
            tpsg_pkg::JMP_HOLD_IN:  step_next = status.in_valid ? ctl.target : step_reg;
            tpsg_pkg::JMP_HOLD_OUT: step_next = status.out_busy ? step_reg : ctl.target;
            default:                step_next = tpsg_pkg::STEP_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= tpsg_pkg::STEP_FETCH;
        else
            step_reg <= step_next;
    end

    // The program must never run past its last step.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= tpsg_pkg::LAST_STEP)
        else $error("sequencer step counter left the program");

endmodule

// ===== rtl/tpsg_datapath.sv =====
// ============================================================================
// tpsg_datapath
// Phase accumulator, shared multiplier, rounding and result registers,
// driven by the sequencer's control word.
// ============================================================================
module tpsg_datapath #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SINE_OUT_BITS  = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tpsg_pkg::ctl_t                         ctl,
    output tpsg_pkg::stat_t                        status,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_index,
    input  logic [tpsg_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   in_valid,
    input  logic [tpsg_pkg::SPEED_BITS-1:0]        speed_rpm,
    input  logic [tpsg_pkg::AMP_BITS-1:0]          amplitude,
    input  logic [tpsg_pkg::RIPPLE_BITS-1:0]       ripple,
    output logic [SINE_ADDR_BITS-1:0]              rom_addr,
    input  logic [SINE_OUT_BITS-2:0]               rom_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_a,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_b,
    output logic signed [tpsg_pkg::RESULT_BITS-1:0] phase_c,
    output logic [tpsg_pkg::RESULT_BITS-1:0]       dc_bus
);

    localparam int RB   = tpsg_pkg::RESULT_BITS;
    localparam int MAGW = SINE_OUT_BITS - 1;
    localparam int AW   = tpsg_pkg::CFG_DATA_BITS;
    localparam int BW   = (MAGW > tpsg_pkg::SPEED_BITS) ? MAGW : tpsg_pkg::SPEED_BITS;
    localparam int PW   = AW + BW;
    localparam int TW   = SINE_ADDR_BITS + 2;

    localparam logic [63:0] THIRD_W     = ((64'd1 << PHASE_BITS) + 64'd1) / 64'd3;
    localparam logic [63:0] TWO_THIRD_W = ((64'd1 << (PHASE_BITS + 1)) + 64'd1) / 64'd3;
    localparam logic [PHASE_BITS-1:0] PH_THIRD      = THIRD_W[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] PH_TWO_THIRDS = TWO_THIRD_W[PHASE_BITS-1:0];
    localparam logic [PHASE_BITS-1:0] PH_QUARTER    = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PW-1:0]         ROUND_HALF    = PW'(1) << (SINE_OUT_BITS - 2);

    // Configuration
    logic [15:0] gain_reg;
    logic [9:0]  dc_reg;

    // Item and state
    logic [tpsg_pkg::SPEED_BITS-1:0]  speed_reg;
    logic [tpsg_pkg::AMP_BITS-1:0]    amp_reg;
    logic [tpsg_pkg::RIPPLE_BITS-1:0] rip_reg;
    logic [PHASE_BITS-1:0]            acc_reg;

    // Sine lookup and multiplier pipeline
    logic [PHASE_BITS-1:0] ph_sum;
    logic [PHASE_BITS-1:0] ph_ofs;
    logic [TW-1:0]         ph_top;
    logic                  neg_reg;
    logic                  sgn_reg;
    logic [AW-1:0]         mul_a;
    logic [BW-1:0]         mul_b;
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         rnd;
    logic [RB-1:0]         mag_r;
    logic [RB-1:0]         sval;
    logic signed [RB:0]    bus_sum;

    // Results
    logic [RB-1:0] res_a_reg, res_b_reg, res_c_reg, res_bus_reg;
    logic [RB-1:0] out_a_reg, out_b_reg, out_c_reg, out_bus_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          accept;
    logic          emit_fire;

    assign status.in_valid = in_valid;
    assign status.out_busy = out_valid_reg && out_stall;
    assign accept          = ctl.take_in && in_valid;
    assign emit_fire       = ctl.emit && !status.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= tpsg_pkg::PHASE_GAIN_RESET;
            dc_reg   <= tpsg_pkg::DC_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == tpsg_pkg::REG_PHASE_GAIN)
                gain_reg <= cfg_data;
            else
                dc_reg <= cfg_data[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg <= speed_rpm;
            amp_reg   <= amplitude;
            rip_reg   <= ripple;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.acc_upd)
            acc_reg <= acc_reg + PHASE_BITS'(prod_reg);
    end

    // Table address: top two phase bits pick the quadrant, odd quadrants
    // read the table mirrored, the upper half turn is negated.
    always_comb
    begin
        case (ctl.ofs_sel)
            tpsg_pkg::OFS_THIRD:      ph_ofs = PH_THIRD;
            tpsg_pkg::OFS_TWO_THIRDS: ph_ofs = PH_TWO_THIRDS;
            tpsg_pkg::OFS_QUARTER:    ph_ofs = PH_QUARTER;
            default:                  ph_ofs = '0;
        endcase
        ph_sum   = acc_reg + ph_ofs;
        ph_top   = ph_sum[PHASE_BITS-1 -: TW];
        rom_addr = ph_top[SINE_ADDR_BITS] ? ~ph_top[SINE_ADDR_BITS-1:0]
                                          : ph_top[SINE_ADDR_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= ph_top[TW-1];
    end

    always_comb
    begin
        case (ctl.mul_sel)
            tpsg_pkg::MUL_INC:
            begin
                mul_a = gain_reg;
                mul_b = BW'(speed_reg);
            end
            tpsg_pkg::MUL_AMP:
            begin
                mul_a = AW'(amp_reg);
                mul_b = BW'(rom_data);
            end
            tpsg_pkg::MUL_RIP:
            begin
                mul_a = AW'(rip_reg);
                mul_b = BW'(rom_data);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_sel != tpsg_pkg::MUL_NONE)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
            sgn_reg  <= neg_reg;
        end
    end

    // Round half away from zero on the magnitude, then apply the sign.
    always_comb
    begin
        rnd     = (prod_reg + ROUND_HALF) >> (SINE_OUT_BITS - 1);
        mag_r   = rnd[RB-1:0];
        sval    = sgn_reg ? (RB'(0) - mag_r) : mag_r;
        bus_sum = $signed({2'b00, dc_reg}) + $signed({sval[RB-1], sval});
    end

    always_ff @(posedge clk)
    begin
        case (ctl.wr_sel)
            tpsg_pkg::WR_A:   res_a_reg <= sval;
            tpsg_pkg::WR_B:   res_b_reg <= sval;
            tpsg_pkg::WR_C:   res_c_reg <= sval;
            tpsg_pkg::WR_BUS: res_bus_reg <= bus_sum[RB] ? '0 : bus_sum[RB-1:0];
            default:          ;
        endcase
        if (emit_fire)
        begin
            out_a_reg   <= res_a_reg;
            out_b_reg   <= res_b_reg;
            out_c_reg   <= res_c_reg;
            out_bus_reg <= res_bus_reg;
        end
    end

    always_comb
    begin
        out_valid_next = emit_fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign phase_a   = $signed(out_a_reg);
    assign phase_b   = $signed(out_b_reg);
    assign phase_c   = $signed(out_c_reg);
    assign dc_bus    = out_bus_reg;

    // The accumulator only moves in its own microcode step.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(ctl.acc_upd) |-> $stable(acc_reg))
        else $error("phase accumulator changed outside its update step");

    // Scaled phase currents never reach the most negative code.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_a_reg != 11'h400) && (out_b_reg != 11'h400)
                          && (out_c_reg != 11'h400))
        else $error("phase output out of range");

    // The bus value stays within the largest DC level plus full ripple.
    a_bus_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_bus_reg <= tpsg_pkg::DC_BUS_MAX)
        else $error("dc bus output out of range");

endmodule

// ===== tb/tb_three_phase_sine_generator_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_three_phase_sine_generator_core
// Self-checking bench for the three-phase sine generator. Requests are sent back to
// back or in bursts while the result side stalls on its own pattern. A bit-accurate
// predictor tracks the phase accumulator and both registers, and every result
// is compared field by field against the oldest predicted sample.
// ============================================================================
module tb_three_phase_sine_generator_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_REQUESTS = 80;

    localparam int RB  = tpsg_pkg::RESULT_BITS;
    localparam int CDB = tpsg_pkg::CFG_DATA_BITS;
    localparam int SPB = tpsg_pkg::SPEED_BITS;
    localparam int AMB = tpsg_pkg::AMP_BITS;
    localparam int RPB = tpsg_pkg::RIPPLE_BITS;

    typedef struct packed {
        logic signed [RB-1:0] phase_a;
        logic signed [RB-1:0] phase_b;
        logic signed [RB-1:0] phase_c;
        logic [RB-1:0]        dc_bus;
    } phase_sample_t;

    class sine_scoreboard;
        localparam bit [31:0] THIRD_TURN      = 32'd1431655765;
        localparam bit [31:0] TWO_THIRDS_TURN = 32'd2863311531;
        localparam bit [31:0] QUARTER_TURN    = 32'h4000_0000;

        bit [31:0]     phase_acc;
        bit [15:0]     phase_gain;
        bit [9:0]      dc_level;
        int unsigned   quarter_wave [1024];
        phase_sample_t pending_samples [$];
        int            errors;

        function new();
            bit [63:0] angle;
            bit [63:0] power;
            bit [63:0] total;
            // Quarter-wave table from a Q30 Taylor series, sampled at bin centers.
            for (int idx = 0; idx < 1024; idx++)
            begin
                angle = (tpsg_pkg::HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> 11;
                power = angle;
                total = angle;
                for (int k = 1; k <= 12; k++)
                begin
                    power = (power * angle) >> 30;
                    power = (power * angle) >> 30;
                    power = power / (64'(2 * k) * 64'(2 * k + 1));
                    if (k % 2 == 1)
                        total = total - power;
                    else
                        total = total + power;
                end
                quarter_wave[idx] = int'((total * 64'd2047 + (64'd1 << 29)) >> 30);
            end
            phase_acc  = '0;
            phase_gain = tpsg_pkg::PHASE_GAIN_RESET;
            dc_level   = tpsg_pkg::DC_LEVEL_RESET;
            errors     = 0;
        endfunction

        function void write_register(logic idx, logic [CDB-1:0] data);
            if (idx == tpsg_pkg::REG_PHASE_GAIN)
                phase_gain = data;
            else if (idx == tpsg_pkg::REG_DC_LEVEL)
                dc_level = data[9:0];
        endfunction

        // Scales a value by the sine of a phase, rounding half away from zero.
        function longint scaled_sine(int unsigned value, bit [31:0] ph);
            bit [9:0] addr;
            longint   prod;
            addr = ph[29:20];
            if (ph[30])
                addr = ~addr;
            prod = longint'((longint'(value) * quarter_wave[addr] + 1024) >> 11);
            return ph[31] ? -prod : prod;
        endfunction

        function void note_request(bit [14:0] speed, bit [9:0] amp, bit [7:0] rip);
            phase_sample_t s;
            longint        bus;
            phase_acc = phase_acc + speed * phase_gain;
            s.phase_a = 11'(scaled_sine(amp, phase_acc));
            s.phase_b = 11'(scaled_sine(amp, phase_acc + THIRD_TURN));
            s.phase_c = 11'(scaled_sine(amp, phase_acc + TWO_THIRDS_TURN));
            bus = longint'(dc_level) + scaled_sine(rip, phase_acc + QUARTER_TURN);
            if (bus < 0)
                bus = 0;
            s.dc_bus = 11'(bus);
            pending_samples.push_back(s);
        endfunction

        function void compare_field(string name, logic [10:0] expected, logic [10:0] actual,
                                    bit is_signed);
            if (actual !== expected)
            begin
                errors++;
                if (is_signed)
                    $error("%s: expected %0d, actual %0d", name, $signed(expected),
                           $signed(actual));
                else
                    $error("%s: expected %0d, actual %0d", name, expected, actual);
            end
        endfunction

        function void check_result(logic [10:0] a, logic [10:0] b, logic [10:0] c,
                                   logic [10:0] bus);
            phase_sample_t s;
            if (pending_samples.size() == 0)
            begin
                errors++;
                $error("result arrived with no request outstanding");
                return;
            end
            s = pending_samples.pop_front();
            compare_field("phase_a", s.phase_a, a, 1'b1);
            compare_field("phase_b", s.phase_b, b, 1'b1);
            compare_field("phase_c", s.phase_c, c, 1'b1);
            compare_field("dc_bus", s.dc_bus, bus, 1'b0);
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic           cfg_index = tpsg_pkg::REG_PHASE_GAIN;
    logic [CDB-1:0] cfg_data  = '0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    logic [SPB-1:0] speed_rpm = '0;
    logic [AMB-1:0] amplitude = '0;
    logic [RPB-1:0] ripple    = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [RB-1:0]  phase_a;
    logic [RB-1:0]  phase_b;
    logic [RB-1:0]  phase_c;
    logic [RB-1:0]  dc_bus;

    sine_scoreboard sb;
    int             idle_cycles = 0;
    int             stall_run   = 0;
    bit             stalling    = 1'b0;

    three_phase_sine_generator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .speed_rpm (speed_rpm),
        .amplitude (amplitude),
        .ripple    (ripple),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .phase_a   (phase_a),
        .phase_b   (phase_b),
        .phase_c   (phase_c),
        .dc_bus    (dc_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: alternating stall and flow runs, with long flow stretches mixed in.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stalling  = !stalling && ($urandom_range(0, 3) != 0);
            stall_run = stalling ? $urandom_range(1, 12) : $urandom_range(1, 30);
        end
        else
            stall_run--;
        out_stall <= stalling;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.write_register(cfg_index, cfg_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (in_valid && !in_stall)
                sb.note_request(speed_rpm, amplitude, ripple);
            if (out_valid && !out_stall)
                sb.check_result(phase_a, phase_b, phase_c, dc_bus);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("three_phase_sine_generator_core verification failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SPB-1:0] s, input logic [AMB-1:0] a,
                               input logic [RPB-1:0] r);
        @(negedge clk);
        in_valid  <= 1'b1;
        speed_rpm <= s;
        amplitude <= a;
        ripple    <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic write_register(input logic idx, input logic [CDB-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drops the request line, waits for every outstanding result and lets the
    // sequencer come back to its first step.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_samples(input int count, input bit eager);
        int             burst_left;
        int             gap;
        logic [SPB-1:0] s;
        logic [AMB-1:0] a;
        logic [RPB-1:0] r;
        burst_left = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0:       s = '0;
                1:       s = '1;
                2, 3:    s = SPB'($urandom_range(0, 255));
                default: s = SPB'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 7))
                0:       a = '0;
                1:       a = '1;
                default: a = AMB'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 7))
                0:       r = '0;
                1:       r = '1;
                default: r = RPB'($urandom_range(0, 255));
            endcase
            send_sample(s, a, r);
            if (!eager)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = $urandom_range(1, 20);
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                    burst_left = $urandom_range(1, 8);
                end
            end
        end
    endtask

    initial
    begin
        logic [CDB-1:0] gain;
        logic [CDB-1:0] level;
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: zero request, full scale at phase zero, then
        // full speed steps that walk the phase through every quadrant.
        send_sample('0, '0, '0);
        send_sample('0, '1, '1);
        send_sample('1, '1, '1);
        for (int i = 0; i < 10; i++)
            send_sample('1, '1, '1);
        send_sample(15'h5555, 10'h2AA, 8'h55);
        send_sample(15'h2AAA, 10'h155, 8'hAA);

        // Largest gain with no DC level: the bus clamps at zero on negative cosine.
        // The level write also carries junk above the register width.
        settle();
        write_register(tpsg_pkg::REG_PHASE_GAIN, 16'hFFFF);
        write_register(tpsg_pkg::REG_DC_LEVEL, 16'hFC00);
        for (int i = 0; i < 4; i++)
            send_sample('1, '1, '1);
        for (int i = 0; i < 4; i++)
            send_sample(15'h2AAA, '1, '1);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    gain  = tpsg_pkg::PHASE_GAIN_RESET;
                    level = CDB'(tpsg_pkg::DC_LEVEL_RESET);
                end
                1:
                begin
                    gain  = '0;
                    level = 16'h03FF;
                end
                2:
                begin
                    gain  = '1;
                    level = '0;
                end
                3:
                begin
                    gain  = 16'd40000;
                    level = 16'hA064;
                end
                default:
                begin
                    gain  = CDB'($urandom_range(0, 65535));
                    level = CDB'($urandom_range(0, 65535));
                end
            endcase
            settle();
            write_register(tpsg_pkg::REG_PHASE_GAIN, gain);
            write_register(tpsg_pkg::REG_DC_LEVEL, level);
            run_samples(PHASE_REQUESTS, p % 2 == 1);
        end

        settle();
        if (sb.errors == 0)
            $display("three_phase_sine_generator_core verification clean");
        else
            $display("three_phase_sine_generator_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tpsg_pkg.sv
rtl/tpsg_sine_rom.sv
rtl/tpsg_sequencer.sv
rtl/tpsg_datapath.sv
rtl/three_phase_sine_generator_core.sv
tb/tb_three_phase_sine_generator_core.sv
